FILE: rtl/core/ips_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the indexed priority server.
package ips_pkg;

  localparam int KIND_W    = 2;
  localparam int ID_W      = 6;
  localparam int AMOUNT_W  = 16;
  localparam int STAMP_W   = 32;
  localparam int S_TDATA_W = 24;  // entry_id + amount, padded to bytes
  localparam int M_TDATA_W = 8;   // served_id, padded to a byte

  typedef enum logic [KIND_W-1:0] {
    OP_ARRIVE = 2'd0,
    OP_RAISE  = 2'd1,
    OP_LEAVE  = 2'd2,
    OP_SERVE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ID_W-1:0]     id;
    logic [AMOUNT_W-1:0] amount;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAISE,
    ST_SCAN,
    ST_SCAN_END,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/core/ips_front.sv
`timescale 1ns / 1ps
// Front end: takes input transactions, decodes them and drops out-of-table ids.
module ips_front
  import ips_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [KIND_W-1:0]    s_tuser,
  output logic                 push,
  output cmd_t                 push_cmd,
  input  logic                 q_full
);

  logic in_range;
  logic keep;
  logic busy;

  // busy blocks the first cycle out of reset so the queue settles empty
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_comb begin
    push_cmd.op     = op_t'(s_tuser);
    push_cmd.id     = s_tdata[ID_W-1:0];
    push_cmd.amount = s_tdata[ID_W +: AMOUNT_W];
    in_range        = 32'(push_cmd.id) < ENTRIES;
    // serve ignores the id; other ops outside the table have no effect
    keep            = (push_cmd.op == OP_SERVE) || in_range;
  end

  assign s_tready = !q_full && !busy;
  assign push     = s_tvalid && s_tready && keep;

endmodule

FILE: rtl/core/ips_cmd_fifo.sv
`timescale 1ns / 1ps
// Two-entry command queue between front end and execution back end.
module ips_cmd_fifo
  import ips_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head  = slots[rd_ptr];
  assign full  = count == 2'd2;
  assign empty = count == 2'd0;

endmodule

FILE: rtl/core/ips_back.sv
`timescale 1ns / 1ps
// Back end: entry table, arrival counter, serve scan and the result register.
module ips_back
  import ips_pkg::*;
#(
  parameter int ENTRIES       = 64,
  parameter int PRIORITY_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 head,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SUM_W = ((PRIORITY_BITS > AMOUNT_W) ? PRIORITY_BITS : AMOUNT_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [PRIORITY_BITS-1:0] PRIO_MAX = {PRIORITY_BITS{1'b1}};
  localparam logic [SUM_W-1:0] PRIO_MAX_EXT = SUM_W'(PRIO_MAX);

  state_t state, state_next;

  logic [PRIORITY_BITS-1:0] prio_mem  [ENTRIES];
  logic [STAMP_W-1:0]       stamp_mem [ENTRIES];
  logic [PRIORITY_BITS-1:0] prio_rd;
  logic [STAMP_W-1:0]       stamp_rd;

  logic [ENTRIES-1:0]  flags;
  logic [STAMP_W-1:0]  arrival_counter;
  logic [IDX_W-1:0]    cur_idx;
  logic [AMOUNT_W-1:0] cur_amount;
  logic [IDX_W-1:0]    scan_cnt;

  // compare stage, one entry behind the read port
  logic                     cmp_valid;
  logic                     cmp_wait;
  logic [IDX_W-1:0]         cmp_idx;
  logic                     found;
  logic [IDX_W-1:0]         best_idx;
  logic [PRIORITY_BITS-1:0] best_prio;
  logic [STAMP_W-1:0]       best_stamp;
  logic                     take;

  logic [IDX_W-1:0]         hidx;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         wr_addr;
  logic                     prio_we;
  logic                     arrive_do;
  logic                     leave_do;
  logic                     serve_done;
  logic                     out_free;
  logic [SUM_W-1:0]         arrive_ext;
  logic [SUM_W-1:0]         raise_sum;
  logic [PRIORITY_BITS-1:0] prio_wdata;
  logic [ID_W-1:0]          served_id;

  assign hidx     = IDX_W'(head.id);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          if (head.op == OP_SERVE) begin
            state_next = ST_SCAN;
          end else if (head.op == OP_RAISE && flags[hidx]) begin
            state_next = ST_RAISE;
          end
        end
      end
      ST_RAISE:    state_next = ST_IDLE;
      ST_SCAN: begin
        if (scan_cnt == LAST_IDX) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!found || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = (state == ST_IDLE) && !q_empty;
    arrive_do  = pop && (head.op == OP_ARRIVE);
    leave_do   = pop && (head.op == OP_LEAVE);
    serve_done = (state == ST_FINISH) && found && out_free;
    rd_addr    = (state == ST_SCAN) ? scan_cnt : hidx;
    prio_we    = arrive_do || (state == ST_RAISE);
    wr_addr    = (state == ST_RAISE) ? cur_idx : hidx;
    arrive_ext = SUM_W'(head.amount);
    raise_sum  = SUM_W'(prio_rd) + SUM_W'(cur_amount);
    if (state == ST_RAISE) begin
      prio_wdata = (raise_sum > PRIO_MAX_EXT) ? PRIO_MAX : PRIORITY_BITS'(raise_sum);
    end else begin
      prio_wdata = (arrive_ext > PRIO_MAX_EXT) ? PRIO_MAX : PRIORITY_BITS'(arrive_ext);
    end
    // higher priority wins, then earlier stamp; strict compare keeps lowest index
    take = cmp_valid && cmp_wait &&
           (!found || (prio_rd > best_prio) ||
            ((prio_rd == best_prio) && (stamp_rd < best_stamp)));
  end

  always_ff @(posedge clk) begin
    if (prio_we) begin
      prio_mem[wr_addr] <= prio_wdata;
    end
    prio_rd <= prio_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (arrive_do) begin
      stamp_mem[hidx] <= arrival_counter + 1'b1;
    end
    stamp_rd <= stamp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      flags           <= '0;
      arrival_counter <= '0;
      scan_cnt        <= '0;
      cmp_valid       <= 1'b0;
      found           <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= (state == ST_SCAN);
      if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end else begin
        scan_cnt <= '0;
      end
      if (arrive_do) begin
        arrival_counter <= arrival_counter + 1'b1;
        flags[hidx]     <= 1'b1;
      end
      if (leave_do) begin
        flags[hidx] <= 1'b0;
      end
      if (serve_done) begin
        flags[best_idx] <= 1'b0;
      end
      if (pop && head.op == OP_SERVE) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if (serve_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_idx    <= hidx;
      cur_amount <= head.amount;
    end
    cmp_idx  <= scan_cnt;
    cmp_wait <= flags[scan_cnt];
    if (take) begin
      best_idx   <= cmp_idx;
      best_prio  <= prio_rd;
      best_stamp <= stamp_rd;
    end
    if (serve_done) begin
      served_id <= ID_W'(best_idx);
    end
  end

  assign m_tdata = M_TDATA_W'(served_id);

endmodule

FILE: rtl/core/indexed_priority_server.sv
`timescale 1ns / 1ps
// Top level of the indexed priority server: front end, command queue, back end.
//
//  channel  direction  tdata (low bit up)                      tuser
//  s_*      in         entry_id[5:0], amount[21:6], pad 23:22  kind[1:0]
//  m_*      out        served_id[5:0], pad 7:6                 -
//
// Arrive and leave are done in the back end as they are popped; raise on a waiting
// entry also passes ST_RAISE (memory read, then saturating add and write back).
// Serve visits all ENTRIES: one comparator walks the priority and stamp memories
// through their single read port, one entry per cycle.
// Reset (rst, synchronous) clears waiting flags, arrival counter and the queue;
// the table memories need no clearing. s_tready is low the cycle after reset.
// The two-entry queue keeps taking transactions, until it is full, while the back
// end scans or a result waits in the output register for m_tready.
module indexed_priority_server
  import ips_pkg::*;
#(
  parameter int ENTRIES       = 64,
  parameter int PRIORITY_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // entry_id[5:0], amount[21:6], zero pad
  input  logic [KIND_W-1:0]    s_tuser,   // kind[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // served_id[5:0], zero pad
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t head;

  // decode; out-of-table arrive/raise/leave never reach the queue
  ips_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  ips_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  // table state lives here; commands run strictly in order
  ips_back #(
    .ENTRIES       (ENTRIES),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: rtl/core/ips_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the indexed priority server, bound to the top level.
module ips_checker
  import ips_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic [KIND_W-1:0]    s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // a stalled result holds its id
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_rst_no_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present right after reset");

  a_rst_hold_in: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready during reset settle cycle");

  // pad bits above served_id stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_TDATA_W-1:ID_W] == '0)
    else $error("nonzero pad bits in result");

endmodule

bind indexed_priority_server ips_checker u_ips_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: tb/indexed_priority_server_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the indexed priority server: directed and random command streams.
module indexed_priority_server_test;
  import ips_pkg::*;

  localparam int TABLE_SIZE = 64;
  localparam int PRIO_W     = 24;
  localparam logic [PRIO_W-1:0] PRIO_TOP = {PRIO_W{1'b1}};
  localparam int SCAN_TAIL  = TABLE_SIZE + 16;  // serve latency plus margin
  localparam int RANDOM_ITEMS = 215;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0]    s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  // shadow copy of the server table
  logic              shadow_waiting [TABLE_SIZE];
  logic [PRIO_W-1:0] shadow_prio    [TABLE_SIZE];
  logic [31:0]       shadow_stamp   [TABLE_SIZE];
  logic [31:0]       shadow_arrivals;

  logic [ID_W-1:0] served_fifo [$];  // ids still owed by the server

  bit idle_on = 1'b1;
  int fail_count  = 0;
  int sent_count  = 0;
  int served_seen = 0;
  int empty_serves = 0;

  always #5 clk = ~clk;

  indexed_priority_server dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Applies one accepted command to the shadow table; a serve that finds a
  // waiting entry queues the id the server must return.
  function automatic void track_command(op_t op, logic [ID_W-1:0] id,
                                        logic [AMOUNT_W-1:0] amount);
    logic [PRIO_W:0] sum;
    int best;
    best = -1;
    case (op)
      OP_ARRIVE: begin
        shadow_arrivals = shadow_arrivals + 32'd1;
        shadow_prio[id]    = PRIO_W'(amount);
        shadow_stamp[id]   = shadow_arrivals;
        shadow_waiting[id] = 1'b1;
      end
      OP_RAISE: begin
        if (shadow_waiting[id]) begin
          sum = {1'b0, shadow_prio[id]} + (PRIO_W+1)'(amount);
          shadow_prio[id] = (sum > {1'b0, PRIO_TOP}) ? PRIO_TOP : sum[PRIO_W-1:0];
        end
      end
      OP_LEAVE: begin
        shadow_waiting[id] = 1'b0;
      end
      default: begin
        // highest priority, then oldest stamp, then lowest index
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if (shadow_waiting[i]) begin
            if (best < 0 || shadow_prio[i] > shadow_prio[best] ||
                (shadow_prio[i] == shadow_prio[best] &&
                 shadow_stamp[i] < shadow_stamp[best]))
              best = i;
          end
        end
        if (best < 0) begin
          empty_serves++;
        end else begin
          shadow_waiting[best] = 1'b0;
          served_fifo.push_back(ID_W'(best));
        end
      end
    endcase
  endfunction

  // Drives one transaction; returns at the edge where it was accepted with
  // tvalid still high, so back-to-back items need no extra assignment.
  task automatic send_command(op_t op, logic [ID_W-1:0] id, logic [AMOUNT_W-1:0] amount);
    while (idle_on && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(S_TDATA_W-ID_W-AMOUNT_W){1'b0}}, amount, id};
    do @(posedge clk); while (!s_tready);
    track_command(op, id, amount);
    sent_count++;
  endtask

  // Holds the input side off until every owed result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (served_fifo.size() != 0) @(posedge clk);
  endtask

  // Output side: random back-pressure and the result check.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (served_fifo.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual served_id %0d",
                 $time, m_tdata[ID_W-1:0]);
        fail_count++;
      end else begin
        if (m_tdata !== M_TDATA_W'(served_fifo[0])) begin
          $display("%0t: served_id mismatch, expected %0d, actual 0x%02h",
                   $time, served_fifo[0], m_tdata);
          fail_count++;
        end
        void'(served_fifo.pop_front());
        served_seen++;
      end
    end
    m_tready <= idle_on ? ($urandom_range(99) >= 20) : 1'b1;
  end

  // Empty serves, extreme ids and amounts on arrive and serve.
  task automatic test_extremes();
    send_command(OP_SERVE, 6'd0, 16'd0);         // nothing waiting
    send_command(OP_ARRIVE, 6'd0, 16'd0);
    send_command(OP_ARRIVE, 6'd63, 16'hFFFF);
    send_command(OP_SERVE, 6'd63, 16'hFFFF);     // id and amount ignored
    send_command(OP_SERVE, 6'd21, 16'h5555);
    send_command(OP_SERVE, 6'd42, 16'hAAAA);     // empty again
  endtask

  // Equal priorities resolve by arrival; re-arrival takes a fresh stamp.
  task automatic test_ties();
    send_command(OP_ARRIVE, 6'd10, 16'd100);
    send_command(OP_ARRIVE, 6'd3, 16'd100);
    send_command(OP_ARRIVE, 6'd30, 16'd100);
    send_command(OP_ARRIVE, 6'd10, 16'd100);     // 10 goes to the back
    send_command(OP_SERVE, 6'd0, 16'd0);
    send_command(OP_SERVE, 6'd0, 16'd0);
    send_command(OP_SERVE, 6'd0, 16'd0);
    send_command(OP_SERVE, 6'd0, 16'd0);
  endtask

  // Raise and leave on idle and on waiting entries.
  task automatic test_raise_leave();
    send_command(OP_RAISE, 6'd5, 16'd900);       // not waiting: ignored
    send_command(OP_LEAVE, 6'd6, 16'd0);         // not waiting: ignored
    send_command(OP_ARRIVE, 6'd5, 16'd10);
    send_command(OP_ARRIVE, 6'd6, 16'd50);
    send_command(OP_ARRIVE, 6'd7, 16'd40);
    send_command(OP_RAISE, 6'd5, 16'd45);        // 5 now on top
    send_command(OP_LEAVE, 6'd6, 16'd0);
    send_command(OP_SERVE, 6'd0, 16'd0);
    send_command(OP_SERVE, 6'd0, 16'd0);
    send_command(OP_SERVE, 6'd0, 16'd0);
  endtask

  // Raising 44 past the top priority clamps it there; a wrapped sum would
  // fall below the older entry 12 and change the serve order.
  task automatic test_saturation();
    send_command(OP_ARRIVE, 6'd12, 16'hFFFF);
    send_command(OP_ARRIVE, 6'd44, 16'hFFFF);
    for (int i = 0; i < 256; i++) send_command(OP_RAISE, 6'd44, 16'hFFFF);
    send_command(OP_RAISE, 6'd44, 16'd1);        // already at the top
    send_command(OP_SERVE, 6'd0, 16'd0);
    send_command(OP_SERVE, 6'd0, 16'd0);
    wait_drained();                              // sender holds until all results are back
  endtask

  // Mostly arrivals and serves on a small id pool so that ties and raises
  // on waiting entries are common; full-range ids and amounts mixed in.
  task automatic test_random();
    op_t op;
    logic [ID_W-1:0] id;
    logic [AMOUNT_W-1:0] amount;
    int pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 80 && n < 160);           // one stretch at full rate
      pick = $urandom_range(99);
      if (pick < 35)      op = OP_ARRIVE;
      else if (pick < 55) op = OP_RAISE;
      else if (pick < 65) op = OP_LEAVE;
      else                op = OP_SERVE;
      id = ($urandom_range(99) < 60) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 25)      amount = AMOUNT_W'($urandom_range(3));
      else if (pick < 35) amount = 16'hFFFF;
      else if (pick < 45) amount = 16'd0;
      else                amount = AMOUNT_W'($urandom);
      send_command(op, id, amount);
      if (n % 100 == 99) wait_drained();
    end
    s_tvalid <= 1'b0;
    idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      shadow_waiting[i] = 1'b0;
      shadow_prio[i]    = '0;
      shadow_stamp[i]   = '0;
    end
    shadow_arrivals = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_ties();
    test_raise_leave();
    test_saturation();
    test_random();
    while (served_fifo.size() != 0) @(posedge clk);
    repeat (SCAN_TAIL) @(posedge clk);
    if (served_fifo.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, served_fifo.size());
      fail_count++;
    end
    $display("Sent %0d commands (ties, raise/leave, saturation, random); %0d ids served,",
             sent_count, served_seen);
    $display("%0d serves on an empty table, with random stalls on both sides.", empty_serves);
    if (fail_count == 0) begin
      $display("indexed_priority_server_test passed");
    end else begin
      $display("indexed_priority_server_test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t: timeout", $time);
    $display("indexed_priority_server_test failed");
    $finish;
  end

endmodule
